// ----- design/mia_pkg.sv -----
// shared constants for the adjugate matrix inverse block
package mia_pkg;

    localparam int ORDER_W       = 3;
    localparam int ORDER_RESET   = 3;
    localparam int N_MAX_DEF     = 4;
    localparam int ELEM_BITS_DEF = 16;
    localparam int OFRAC         = 16;
    localparam int VALUE_W       = 32;
    localparam int POS_W         = 2;

    localparam logic [VALUE_W-1:0] SAT_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam logic [VALUE_W-1:0] SAT_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

endpackage

// ----- design/mia_channels.sv -----
// valid/ready channel interfaces for matrix elements and inverse entries
interface mia_in_if #(
    parameter int ELEM_BITS = mia_pkg::ELEM_BITS_DEF
);
    logic                        valid;
    logic                        ready;
    logic signed [ELEM_BITS-1:0] element;

    modport source (output valid, output element, input ready);
    modport sink   (input valid, input element, output ready);
endinterface

interface mia_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [mia_pkg::VALUE_W-1:0]   value;
    logic        [mia_pkg::POS_W-1:0]     row;
    logic        [mia_pkg::POS_W-1:0]     col;
    logic                                 singular;
    logic                                 last;

    modport source (output valid, output value, output row, output col,
                    output singular, output last, input ready);
    modport sink   (input valid, input value, input row, input col,
                    input singular, input last, output ready);
endinterface

// ----- design/matrix_inverse_adjugate.sv -----
// matrix inverse by adjugate: element store, cofactor sequencer and output register
//
// in_ch takes one signed Q8.8 element per transaction, row-major, n*n of them
// (n = order register, 0 acts as 1, above N_MAX acts as N_MAX). Writing the
// order register drops any partly loaded matrix. in_ch is ready only while
// loading; during computation it is held low.
// Every determinant is a sum over permutations of products of elements read
// from the element memory, one element per read and one shift-add per element
// bit. The determinant (the n x n minor) comes first; each inverse entry then
// needs one (n-1) x (n-1) minor plus one pass of the restoring divider, and
// the quotient is then moved to the output register.
// out_ch gives n*n Q16.16 entries with row, col and last, or a single
// transaction with singular set when the determinant is zero. When out_ch
// stalls the next finished entry waits and computation pauses; the held entry
// stays stable. Reset sets order to 3 and empties the load and output.
module matrix_inverse_adjugate #(
    parameter int N_MAX     = mia_pkg::N_MAX_DEF,
    parameter int ELEM_BITS = mia_pkg::ELEM_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [mia_pkg::ORDER_W-1:0]   cfg_data,
    mia_in_if.sink                        in_ch,
    mia_out_if.source                     out_ch
);

    localparam int KW    = mia_pkg::ORDER_W;
    localparam int IW    = $clog2(N_MAX);
    localparam int DEPTH = N_MAX * N_MAX;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = N_MAX * ELEM_BITS;
    localparam int SW    = PW + 3 * N_MAX + 1;
    localparam int BW    = $clog2(ELEM_BITS);
    localparam int SHIFT = mia_pkg::OFRAC + ELEM_BITS / 2;

    typedef enum logic [3:0] {
        S_LOAD,
        S_PERM,
        S_ISSUE,
        S_LATCH,
        S_MUL,
        S_MINOR_END,
        S_DIV,
        S_OUT
    } state_t;

    state_t                    state_reg;
    logic [KW-1:0]             order_reg;
    logic [IW-1:0]             ld_row_reg;
    logic [IW-1:0]             ld_col_reg;

    logic [KW-1:0]             k_reg;
    logic                      excl_reg;
    logic [IW-1:0]             er_reg;
    logic [IW-1:0]             ec_reg;
    logic                      det_phase_reg;
    logic [IW-1:0]             digit_reg [N_MAX];
    logic [N_MAX-1:0]          used_reg;
    logic [KW-1:0]             t_reg;
    logic [IW-1:0]             row_reg;
    logic signed [SW-1:0]      sum_reg;
    logic signed [SW-1:0]      det_reg;
    logic [PW-1:0]             prod_reg;
    logic [PW-1:0]             acc_reg;
    logic                      psign_reg;
    logic [ELEM_BITS-1:0]      mult_reg;
    logic [BW-1:0]             bit_reg;
    logic [IW-1:0]             oi_reg;
    logic [IW-1:0]             oj_reg;
    logic                      sing_pend_reg;
    logic                      div_start_reg;

    logic                                 out_valid_reg;
    logic signed [mia_pkg::VALUE_W-1:0]   out_value_reg;
    logic [mia_pkg::POS_W-1:0]            out_row_reg;
    logic [mia_pkg::POS_W-1:0]            out_col_reg;
    logic                                 out_singular_reg;
    logic                                 out_last_reg;

    logic signed [ELEM_BITS-1:0] mem [DEPTH];
    logic signed [ELEM_BITS-1:0] rdata_reg;

    logic [KW-1:0]             n_eff;
    logic                      in_fire;
    logic                      ld_last;
    logic [AW-1:0]             wr_addr;
    logic [AW-1:0]             rd_addr;
    logic [IW-1:0]             col_sel;
    logic [IW-1:0]             digit_next [N_MAX];
    logic                      perm_carry;
    logic                      parity_next;
    logic [IW-1:0]             row_adv;
    logic [IW-1:0]             cof_first_row;
    logic signed [SW-1:0]      sum_next;
    logic [PW-1:0]             acc_next;
    logic [ELEM_BITS-1:0]      elem_mag;
    logic signed [SW-1:0]      cof_val;
    logic [SW-1:0]             adj_mag;
    logic [SW-1:0]             det_mag;
    logic                      div_neg;
    logic                      div_done;
    logic [mia_pkg::VALUE_W-1:0] div_value;
    logic                      entry_last;
    logic [IW-1:0]             next_i;
    logic [IW-1:0]             next_j;

    always_comb
    begin
        if (order_reg == '0)
            n_eff = KW'(1);
        else if (order_reg > KW'(N_MAX))
            n_eff = KW'(N_MAX);
        else
            n_eff = order_reg;
    end

    assign in_fire = in_ch.valid && in_ch.ready;
    assign ld_last = (KW'(ld_row_reg) == n_eff - 1'b1) && (KW'(ld_col_reg) == n_eff - 1'b1);
    assign wr_addr = AW'(ld_row_reg) * AW'(N_MAX) + AW'(ld_col_reg);
    assign rd_addr = AW'(row_reg) * AW'(N_MAX) + AW'(col_sel);

    always_ff @(posedge clk)
    begin
        if (in_fire)
            mem[wr_addr] <= in_ch.element;
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[rd_addr];
    end

    // pick the column of rank digit[t] among those still free
    always_comb
    begin
        logic [KW-1:0] rank;
        logic          found;
        logic          avail;
        col_sel = '0;
        rank    = '0;
        found   = 1'b0;
        for (int c = 0; c < N_MAX; c++)
        begin
            avail = (KW'(c) < n_eff) && !used_reg[c] && !(excl_reg && (ec_reg == IW'(c)));
            if (avail && !found)
            begin
                if (rank == KW'(digit_reg[t_reg[IW-1:0]]))
                begin
                    col_sel = IW'(c);
                    found   = 1'b1;
                end
                else
                    rank = rank + 1'b1;
            end
        end
    end

    // mixed-radix step through the permutation digits; parity gives the term sign
    always_comb
    begin
        logic [KW-1:0] radix;
        perm_carry  = 1'b1;
        parity_next = 1'b0;
        for (int p = N_MAX - 1; p >= 0; p--)
        begin
            digit_next[p] = digit_reg[p];
            radix = k_reg - KW'(p);
            if ((KW'(p) < k_reg) && perm_carry)
            begin
                if (KW'(digit_reg[p]) + KW'(1) == radix)
                    digit_next[p] = '0;
                else
                begin
                    digit_next[p] = digit_reg[p] + 1'b1;
                    perm_carry    = 1'b0;
                end
            end
            parity_next = parity_next ^ digit_next[p][0];
        end
    end

    always_comb
    begin
        row_adv = row_reg + 1'b1;
        if (excl_reg && (row_adv == er_reg))
            row_adv = row_reg + IW'(2);
    end

    assign cof_first_row = (next_j == '0) ? IW'(1) : '0;
    assign sum_next  = psign_reg ? (sum_reg - SW'(prod_reg)) : (sum_reg + SW'(prod_reg));
    assign acc_next  = {acc_reg[PW-2:0], 1'b0} + (mult_reg[ELEM_BITS-1] ? prod_reg : '0);
    assign elem_mag  = rdata_reg[ELEM_BITS-1] ? (~rdata_reg + 1'b1) : rdata_reg;
    assign cof_val   = (oi_reg[0] ^ oj_reg[0]) ? -sum_reg : sum_reg;
    assign adj_mag   = cof_val[SW-1] ? SW'(-cof_val) : SW'(cof_val);
    assign det_mag   = det_reg[SW-1] ? SW'(-det_reg) : SW'(det_reg);
    assign div_neg   = cof_val[SW-1] ^ det_reg[SW-1];
    assign entry_last = (KW'(oi_reg) == n_eff - 1'b1) && (KW'(oj_reg) == n_eff - 1'b1);

    always_comb
    begin
        if (KW'(oj_reg) == n_eff - 1'b1)
        begin
            next_i = oi_reg + 1'b1;
            next_j = '0;
        end
        else
        begin
            next_i = oi_reg;
            next_j = oj_reg + 1'b1;
        end
    end

    mia_divider #(
        .MAG_W (SW),
        .SHIFT (SHIFT)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start_reg),
        .neg     (div_neg),
        .adj_mag (adj_mag),
        .det_mag (det_mag),
        .done    (div_done),
        .value   (div_value)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            order_reg     <= KW'(mia_pkg::ORDER_RESET);
            ld_row_reg    <= '0;
            ld_col_reg    <= '0;
            out_valid_reg <= 1'b0;
            div_start_reg <= 1'b0;
            sing_pend_reg <= 1'b0;
        end
        else
        begin
            div_start_reg <= 1'b0;
            // in S_OUT the output register is refilled whenever it is free
            if (out_ch.ready && (state_reg != S_OUT))
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_LOAD:
                begin
                    if (cfg_write)
                    begin
                        ld_row_reg <= '0;
                        ld_col_reg <= '0;
                    end
                    else if (in_fire)
                    begin
                        if (ld_last)
                        begin
                            ld_row_reg    <= '0;
                            ld_col_reg    <= '0;
                            k_reg         <= n_eff;
                            excl_reg      <= 1'b0;
                            er_reg        <= '0;
                            ec_reg        <= '0;
                            det_phase_reg <= 1'b1;
                            for (int d = 0; d < N_MAX; d++)
                                digit_reg[d] <= '0;
                            used_reg      <= '0;
                            t_reg         <= '0;
                            row_reg       <= '0;
                            sum_reg       <= '0;
                            prod_reg      <= PW'(1);
                            psign_reg     <= 1'b0;
                            state_reg     <= S_PERM;
                        end
                        else if (KW'(ld_col_reg) == n_eff - 1'b1)
                        begin
                            ld_col_reg <= '0;
                            ld_row_reg <= ld_row_reg + 1'b1;
                        end
                        else
                            ld_col_reg <= ld_col_reg + 1'b1;
                    end
                end

                S_PERM:
                begin
                    if (t_reg == k_reg)
                    begin
                        sum_reg   <= sum_next;
                        digit_reg <= digit_next;
                        if (perm_carry)
                            state_reg <= S_MINOR_END;
                        else
                        begin
                            t_reg     <= '0;
                            used_reg  <= '0;
                            row_reg   <= (excl_reg && (er_reg == '0)) ? IW'(1) : '0;
                            prod_reg  <= PW'(1);
                            psign_reg <= parity_next;
                        end
                    end
                    else
                        state_reg <= S_ISSUE;
                end

                S_ISSUE:
                begin
                    used_reg[col_sel] <= 1'b1;
                    state_reg         <= S_LATCH;
                end

                S_LATCH:
                begin
                    mult_reg  <= elem_mag;
                    psign_reg <= psign_reg ^ rdata_reg[ELEM_BITS-1];
                    acc_reg   <= '0;
                    bit_reg   <= '0;
                    state_reg <= S_MUL;
                end

                S_MUL:
                begin
                    acc_reg  <= acc_next;
                    mult_reg <= {mult_reg[ELEM_BITS-2:0], 1'b0};
                    bit_reg  <= bit_reg + 1'b1;
                    if (bit_reg == BW'(ELEM_BITS - 1))
                    begin
                        prod_reg  <= acc_next;
                        t_reg     <= t_reg + 1'b1;
                        row_reg   <= row_adv;
                        state_reg <= S_PERM;
                    end
                end

                S_MINOR_END:
                begin
                    if (det_phase_reg)
                    begin
                        det_reg <= sum_reg;
                        if (sum_reg == '0)
                        begin
                            sing_pend_reg <= 1'b1;
                            state_reg     <= S_OUT;
                        end
                        else
                        begin
                            det_phase_reg <= 1'b0;
                            oi_reg        <= '0;
                            oj_reg        <= '0;
                            k_reg         <= n_eff - 1'b1;
                            excl_reg      <= 1'b1;
                            er_reg        <= '0;
                            ec_reg        <= '0;
                            for (int d = 0; d < N_MAX; d++)
                                digit_reg[d] <= '0;
                            used_reg      <= '0;
                            t_reg         <= '0;
                            row_reg       <= IW'(1);
                            sum_reg       <= '0;
                            prod_reg      <= PW'(1);
                            psign_reg     <= 1'b0;
                            state_reg     <= S_PERM;
                        end
                    end
                    else
                    begin
                        div_start_reg <= 1'b1;
                        state_reg     <= S_DIV;
                    end
                end

                S_DIV:
                begin
                    if (div_done)
                        state_reg <= S_OUT;
                end

                S_OUT:
                begin
                    if (!out_valid_reg || out_ch.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        if (sing_pend_reg)
                        begin
                            out_value_reg    <= '0;
                            out_row_reg      <= '0;
                            out_col_reg      <= '0;
                            out_singular_reg <= 1'b1;
                            out_last_reg     <= 1'b1;
                            sing_pend_reg    <= 1'b0;
                            state_reg        <= S_LOAD;
                        end
                        else
                        begin
                            out_value_reg    <= div_value;
                            out_row_reg      <= mia_pkg::POS_W'(oi_reg);
                            out_col_reg      <= mia_pkg::POS_W'(oj_reg);
                            out_singular_reg <= 1'b0;
                            out_last_reg     <= entry_last;
                            if (entry_last)
                                state_reg <= S_LOAD;
                            else
                            begin
                                // adjugate (i,j) is the cofactor of row j, column i
                                oi_reg    <= next_i;
                                oj_reg    <= next_j;
                                er_reg    <= next_j;
                                ec_reg    <= next_i;
                                for (int d = 0; d < N_MAX; d++)
                                    digit_reg[d] <= '0;
                                used_reg  <= '0;
                                t_reg     <= '0;
                                row_reg   <= cof_first_row;
                                sum_reg   <= '0;
                                prod_reg  <= PW'(1);
                                psign_reg <= 1'b0;
                                state_reg <= S_PERM;
                            end
                        end
                    end
                end

                default:
                    state_reg <= S_LOAD;
            endcase

            // load counters are already clear outside S_LOAD
            if (cfg_write)
                order_reg <= cfg_data;
        end
    end

    assign in_ch.ready     = (state_reg == S_LOAD);
    assign out_ch.valid    = out_valid_reg;
    assign out_ch.value    = out_value_reg;
    assign out_ch.row      = out_row_reg;
    assign out_ch.col      = out_col_reg;
    assign out_ch.singular = out_singular_reg;
    assign out_ch.last     = out_last_reg;

endmodule

// ----- design/mia_divider.sv -----
// restoring divider: rounded, saturated adj * 2^SHIFT / det
module mia_divider #(
    parameter int MAG_W = 80,
    parameter int SHIFT = 24
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic                                neg,
    input  logic [MAG_W-1:0]                    adj_mag,
    input  logic [MAG_W-1:0]                    det_mag,
    output logic                                done,
    output logic [mia_pkg::VALUE_W-1:0]         value
);

    localparam int NW = MAG_W + SHIFT + 2;
    localparam int CW = $clog2(NW + 1);
    localparam int VW = mia_pkg::VALUE_W;

    logic [NW-1:0]    num_reg;
    logic [MAG_W:0]   den_reg;
    logic [MAG_W+1:0] rem_reg;
    logic [VW:0]      q_reg;
    logic             high_reg;
    logic             neg_reg;
    logic [CW-1:0]    cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [MAG_W+1:0] rem_shift;
    logic [MAG_W+1:0] den_ext;
    logic             q_bit;
    logic [MAG_W+1:0] rem_next;
    logic             over;

    always_comb
    begin
        rem_shift = {rem_reg[MAG_W:0], num_reg[NW-1]};
        den_ext   = {1'b0, den_reg};
        q_bit     = (rem_shift >= den_ext);
        rem_next  = q_bit ? (rem_shift - den_ext) : rem_shift;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                // numerator carries half the divisor so truncation rounds to nearest
                num_reg  <= {1'b0, adj_mag, {(SHIFT + 1){1'b0}}} + NW'(det_mag);
                den_reg  <= {det_mag, 1'b0};
                rem_reg  <= '0;
                q_reg    <= '0;
                high_reg <= 1'b0;
                neg_reg  <= neg;
                cnt_reg  <= CW'(NW);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                rem_reg  <= rem_next;
                q_reg    <= {q_reg[VW-1:0], q_bit};
                high_reg <= high_reg | q_reg[VW];
                num_reg  <= {num_reg[NW-2:0], 1'b0};
                cnt_reg  <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        over = high_reg | q_reg[VW];
        if (neg_reg)
        begin
            if (over || (q_reg[VW-1:0] > mia_pkg::SAT_MIN))
                value = mia_pkg::SAT_MIN;
            else
                value = ~q_reg[VW-1:0] + 1'b1;
        end
        else
        begin
            if (over || q_reg[VW-1])
                value = mia_pkg::SAT_MAX;
            else
                value = q_reg[VW-1:0];
        end
    end

    assign done = done_reg;

endmodule

// ----- design/mia_checker.sv -----
// port-level checks for the adjugate matrix inverse block, bound to the top level
module mia_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 in_valid,
    input logic                                 in_ready,
    input logic                                 out_valid,
    input logic                                 out_ready,
    input logic signed [mia_pkg::VALUE_W-1:0]   out_value,
    input logic [mia_pkg::POS_W-1:0]            out_row,
    input logic [mia_pkg::POS_W-1:0]            out_col,
    input logic                                 out_singular,
    input logic                                 out_last
);

    // a singular result is alone and carries no entry
    a_singular_alone: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_singular |-> out_last && out_row == '0 && out_col == '0
                                      && out_value == '0)
        else $error("singular result not a lone zero entry");

    // loading is closed while a matrix is still being delivered
    a_no_load_mid_matrix: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_last |-> !in_ready)
        else $error("element accepted while inverse still being delivered");

    // no result can appear right after an element is taken
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("result appeared one cycle after an element");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_last))
        else $error("stalled result changed");

endmodule

bind matrix_inverse_adjugate mia_checker u_mia_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_value    (out_ch.value),
    .out_row      (out_ch.row),
    .out_col      (out_ch.col),
    .out_singular (out_ch.singular),
    .out_last     (out_ch.last)
);

// ----- verif/tb_matrix_inverse_adjugate.sv -----
// self-checking testbench for the adjugate matrix inverse block
module tb_matrix_inverse_adjugate;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NMAX       = mia_pkg::N_MAX_DEF;
    localparam int EW         = mia_pkg::ELEM_BITS_DEF;
    localparam int CYCLE_MAX  = 1000000;
    localparam int ITEM_GOAL  = 220;

    typedef logic signed [127:0] wide_t;

    typedef struct {
        logic [mia_pkg::VALUE_W-1:0] value;
        logic [mia_pkg::POS_W-1:0]   row;
        logic [mia_pkg::POS_W-1:0]   col;
        logic                        singular;
        logic                        last;
    } entry_t;

    typedef enum logic { OP_ORDER, OP_ELEM } op_t;

    typedef struct {
        op_t                         op;
        logic [EW-1:0]               data;
        logic                        typed;
        logic [mia_pkg::VALUE_W-1:0] exp_value;
        logic                        exp_singular;
    } stim_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write = 1'b0;
    logic [mia_pkg::ORDER_W-1:0] cfg_data = '0;

    mia_in_if #(.ELEM_BITS(EW)) in_ch ();
    mia_out_if out_ch ();

    matrix_inverse_adjugate #(.N_MAX(NMAX), .ELEM_BITS(EW)) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    always #2 clk = ~clk;

    // predictor state
    longint                       mat [NMAX][NMAX];
    int                           load_cnt = 0;
    logic [mia_pkg::ORDER_W-1:0]  order_reg = mia_pkg::ORDER_W'(mia_pkg::ORDER_RESET);
    entry_t                       inverse_q [$];

    int errors = 0;
    int cycles = 0;
    int items = 0;
    int matrices = 0;
    int singulars = 0;
    int entries_seen = 0;
    bit calm = 1'b0;

    function automatic int eff_order();
        if (order_reg == 0) return 1;
        if (order_reg > NMAX) return NMAX;
        return int'(order_reg);
    endfunction

    function automatic wide_t minor_det(input int rs[NMAX], input int cs[NMAX], input int k);
        int sub[NMAX];
        int rsub[NMAX];
        int m;
        wide_t acc;
        wide_t term;
        if (k <= 0) return 1;
        acc = 0;
        for (int i = 0; i < NMAX; i++) rsub[i] = (i + 1 < NMAX) ? rs[i + 1] : 0;
        for (int c = 0; c < k; c++) begin
            m = 0;
            for (int i = 0; i < NMAX; i++) sub[i] = 0;
            for (int j = 0; j < k; j++) if (j != c) begin sub[m] = cs[j]; m++; end
            term = minor_det(rsub, sub, k - 1) * wide_t'(mat[rs[0]][cs[c]]);
            if (c & 1) acc = acc - term;
            else acc = acc + term;
        end
        return acc;
    endfunction

    // adj * 2^(16+8) / det, nearest with ties away from zero, then saturated
    function automatic logic [mia_pkg::VALUE_W-1:0] q16_quotient(input wide_t adj,
                                                                 input wide_t det);
        logic [127:0] na;
        logic [127:0] nd;
        logic [127:0] q;
        bit neg;
        neg = (adj < 0) ^ (det < 0);
        na = (adj < 0) ? -adj : adj;
        nd = (det < 0) ? -det : det;
        q = ((na << (mia_pkg::OFRAC + EW / 2 + 1)) + nd) / (nd << 1);
        if (neg) begin
            if (q > 128'h8000_0000) return mia_pkg::SAT_MIN;
            return mia_pkg::VALUE_W'(-q);
        end
        if (q > 128'h7FFF_FFFF) return mia_pkg::SAT_MAX;
        return q[mia_pkg::VALUE_W-1:0];
    endfunction

    function automatic void predict_inverse(input logic [EW-1:0] raw, input bit keep);
        int n;
        int rs[NMAX];
        int cs[NMAX];
        int m;
        wide_t det;
        wide_t cof;
        entry_t ent;
        n = eff_order();
        mat[load_cnt / n][load_cnt % n] = longint'($signed(raw));
        load_cnt++;
        if (load_cnt < n * n) return;
        load_cnt = 0;
        matrices++;
        for (int i = 0; i < NMAX; i++) begin rs[i] = i; cs[i] = i; end
        det = minor_det(rs, cs, n);
        if (det == 0) begin
            singulars++;
            ent = '{value: '0, row: '0, col: '0, singular: 1'b1, last: 1'b1};
            if (keep) inverse_q.push_back(ent);
            return;
        end
        for (int i = 0; i < n; i++) begin
            for (int j = 0; j < n; j++) begin
                // adjugate (i,j) is the cofactor at row j, column i
                m = 0;
                for (int k = 0; k < NMAX; k++) rs[k] = 0;
                for (int k = 0; k < n; k++) if (k != j) begin rs[m] = k; m++; end
                m = 0;
                for (int k = 0; k < NMAX; k++) cs[k] = 0;
                for (int k = 0; k < n; k++) if (k != i) begin cs[m] = k; m++; end
                cof = minor_det(rs, cs, n - 1);
                if ((i + j) & 1) cof = -cof;
                ent.value = q16_quotient(cof, det);
                ent.row = mia_pkg::POS_W'(i);
                ent.col = mia_pkg::POS_W'(j);
                ent.singular = 1'b0;
                ent.last = (i == n - 1 && j == n - 1);
                if (keep) inverse_q.push_back(ent);
            end
        end
    endfunction

    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // sink side stalls
    int hold = 0;
    always @(posedge clk) begin
        if (hold > 0) begin
            hold <= hold - 1;
        end else if (calm) begin
            out_ch.ready <= 1'b1;
        end else begin
            out_ch.ready <= ($urandom_range(0, 2) != 0);
            hold <= pick_gap();
        end
    end

    always @(posedge clk) begin
        entry_t exp_e;
        cycles <= cycles + 1;
        if (cycles > CYCLE_MAX) begin
            $display("%0t timeout after %0d cycles", $realtime, cycles);
            $display("matrix_inverse_adjugate regression: fail");
            $finish;
        end
        if (rst_n && out_ch.valid && out_ch.ready) begin
            entries_seen <= entries_seen + 1;
            if (inverse_q.size() == 0) begin
                $display("%0t unexpected transaction value=%h row=%0d col=%0d sing=%b last=%b",
                         $realtime, out_ch.value, out_ch.row, out_ch.col,
                         out_ch.singular, out_ch.last);
                errors <= errors + 1;
            end else begin
                exp_e = inverse_q.pop_front();
                if (out_ch.value !== exp_e.value || out_ch.row !== exp_e.row ||
                    out_ch.col !== exp_e.col || out_ch.singular !== exp_e.singular ||
                    out_ch.last !== exp_e.last) begin
                    $display("%0t mismatch exp value=%h row=%0d col=%0d sing=%b last=%b",
                             $realtime, exp_e.value, exp_e.row, exp_e.col,
                             exp_e.singular, exp_e.last);
                    $display("%0t          got value=%h row=%0d col=%0d sing=%b last=%b",
                             $realtime, out_ch.value, out_ch.row, out_ch.col,
                             out_ch.singular, out_ch.last);
                    errors <= errors + 1;
                end
            end
        end
    end

    task automatic send_element(input logic [EW-1:0] d, input bit typed,
                                input logic [mia_pkg::VALUE_W-1:0] exp_value,
                                input logic exp_sing);
        int gap;
        entry_t ent;
        gap = pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.element <= d;
        do @(posedge clk); while (!in_ch.ready);
        items++;
        predict_inverse(d, !typed);
        if (typed) begin
            ent = '{value: exp_value, row: '0, col: '0, singular: exp_sing, last: 1'b1};
            inverse_q.push_back(ent);
        end
    endtask

    // every pending inverse drains before the order changes
    task automatic write_order(input logic [mia_pkg::ORDER_W-1:0] v);
        in_ch.valid <= 1'b0;
        while (inverse_q.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_write <= 1'b0;
        order_reg = v;
        load_cnt = 0;
    endtask

    stim_t directed [] = '{
        '{OP_ELEM,  16'sh0100, 1'b0, 32'h0, 1'b0},
        '{OP_ELEM,  16'sh0000, 1'b0, 32'h0, 1'b0},
        '{OP_ELEM,  16'sh0000, 1'b0, 32'h0, 1'b0},
        '{OP_ELEM,  16'sh0000, 1'b0, 32'h0, 1'b0},
        '{OP_ELEM,  16'sh0200, 1'b0, 32'h0, 1'b0},
        '{OP_ELEM,  16'sh0000, 1'b0, 32'h0, 1'b0},
        '{OP_ELEM,  16'sh0000, 1'b0, 32'h0, 1'b0},
        '{OP_ELEM,  16'sh0000, 1'b0, 32'h0, 1'b0},
        '{OP_ELEM,  16'shFF00, 1'b0, 32'h0, 1'b0},
        '{OP_ORDER, 16'd1,     1'b0, 32'h0, 1'b0},
        '{OP_ELEM,  16'sh0100, 1'b1, 32'h0001_0000, 1'b0},
        '{OP_ELEM,  16'sh0000, 1'b1, 32'h0000_0000, 1'b1},
        '{OP_ELEM,  16'sh0001, 1'b1, 32'h0100_0000, 1'b0},
        '{OP_ELEM,  16'sh8000, 1'b1, 32'hFFFF_FE00, 1'b0},
        '{OP_ELEM,  16'shFFFF, 1'b1, 32'hFF00_0000, 1'b0},
        '{OP_ORDER, 16'd0,     1'b0, 32'h0, 1'b0},
        '{OP_ELEM,  16'sh0200, 1'b1, 32'h0000_8000, 1'b0},
        '{OP_ORDER, 16'd2,     1'b0, 32'h0, 1'b0},
        '{OP_ELEM,  16'sh1234, 1'b0, 32'h0, 1'b0},
        '{OP_ELEM,  16'sh4321, 1'b0, 32'h0, 1'b0},
        // partial matrix dropped by the rewrite, then a det-one matrix that saturates
        '{OP_ORDER, 16'd2,     1'b0, 32'h0, 1'b0},
        '{OP_ELEM,  16'sh7FFF, 1'b0, 32'h0, 1'b0},
        '{OP_ELEM,  16'sh7FFE, 1'b0, 32'h0, 1'b0},
        '{OP_ELEM,  16'sh0001, 1'b0, 32'h0, 1'b0},
        '{OP_ELEM,  16'sh0001, 1'b0, 32'h0, 1'b0}
    };

    initial begin
        logic [EW-1:0] grid [NMAX][NMAX];
        logic [mia_pkg::ORDER_W-1:0] ov;
        int n;
        int sets;
        int kind;
        int extra;
        in_ch.valid = 1'b0;
        in_ch.element = '0;
        out_ch.ready = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i]) begin
            if (directed[i].op == OP_ORDER)
                write_order(mia_pkg::ORDER_W'(directed[i].data));
            else
                send_element(directed[i].data, directed[i].typed,
                             directed[i].exp_value, directed[i].exp_singular);
        end

        while (items < ITEM_GOAL) begin
            ov = mia_pkg::ORDER_W'($urandom_range(0, 7));
            write_order(ov);
            calm = ($urandom_range(0, 4) == 0);
            n = eff_order();
            sets = (n == NMAX) ? $urandom_range(1, 2) : $urandom_range(1, 4);
            for (int s = 0; s < sets; s++) begin
                kind = $urandom_range(0, 9);
                for (int r = 0; r < n; r++) begin
                    for (int c = 0; c < n; c++) begin
                        case (kind)
                            6, 7: grid[r][c] = EW'($signed($urandom_range(0, 6)) - 3) << 8;
                            8: case ($urandom_range(0, 4))
                                   0: grid[r][c] = 16'sh8000;
                                   1: grid[r][c] = 16'sh7FFF;
                                   2: grid[r][c] = 16'sh0000;
                                   3: grid[r][c] = 16'sh0001;
                                   default: grid[r][c] = 16'shFFFF;
                               endcase
                            default: grid[r][c] = EW'($urandom);
                        endcase
                    end
                end
                // repeated row forces a zero determinant
                if (kind == 9 && n > 1)
                    for (int c = 0; c < n; c++) grid[n - 1][c] = grid[0][c];
                for (int r = 0; r < n; r++)
                    for (int c = 0; c < n; c++)
                        send_element(grid[r][c], 1'b0, '0, 1'b0);
            end
            // occasionally leave a partial matrix for the next order write to drop
            if (n > 1 && $urandom_range(0, 5) == 0) begin
                extra = $urandom_range(1, n * n - 1);
                for (int k = 0; k < extra; k++)
                    send_element(EW'($urandom), 1'b0, '0, 1'b0);
            end
            calm = 1'b0;
        end

        in_ch.valid <= 1'b0;
        while (inverse_q.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        $display("covered %0d elements, %0d matrices (%0d singular), %0d inverse entries",
                 items, matrices, singulars, entries_seen);
        $display("random orders incl. out-of-range values, saturation, dropped partial loads");
        if (errors == 0)
            $display("matrix_inverse_adjugate regression: pass");
        else
            $display("matrix_inverse_adjugate regression: fail");
        $finish;
    end

endmodule
